// File: hdl/bcd_pkg.sv
`default_nettype none

package bcd_pkg;

    localparam int COUNT_WIDTH_DEF = 8;
    localparam int RATIO_W         = 16;
    localparam int CFG_W           = 8;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int DEC_W           = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_NORM  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_SAFE  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_WIN   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPIRAL_LIM = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GOOD_NEED  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_RUN   = 8'd7;

    // register reset values
    localparam logic [RATIO_W-1:0] RST_LOW_THR    = 16'd23040;
    localparam logic [RATIO_W-1:0] RST_HIGH_THR   = 16'd24832;
    localparam logic [CFG_W-1:0]   RST_WAIT_NORM  = 8'd8;
    localparam logic [CFG_W-1:0]   RST_WAIT_SAFE  = 8'd16;
    localparam logic [CFG_W-1:0]   RST_FAIL_WIN   = 8'd4;
    localparam logic [CFG_W-1:0]   RST_SPIRAL_LIM = 8'd3;
    localparam logic [CFG_W-1:0]   RST_GOOD_NEED  = 8'd6;
    localparam logic [CFG_W-1:0]   RST_JUMP_RUN   = 8'd3;

    localparam logic [CFG_W-1:0]   RST_JUMP_NOW   = 8'd1;
    localparam logic [RATIO_W-1:0] RST_PREV_RATIO = 16'd256;

    // decisions
    localparam logic [DEC_W-1:0] DEC_HOLD = 2'd0;
    localparam logic [DEC_W-1:0] DEC_DOWN = 2'd1;
    localparam logic [DEC_W-1:0] DEC_UP   = 2'd2;
    localparam logic [DEC_W-1:0] DEC_JUMP = 2'd3;

    typedef struct packed {
        logic [RATIO_W-1:0] low_thr;
        logic [RATIO_W-1:0] high_thr;
        logic [CFG_W-1:0]   wait_norm;
        logic [CFG_W-1:0]   wait_safe;
        logic [CFG_W-1:0]   fail_win;
        logic [CFG_W-1:0]   spiral_lim;
        logic [CFG_W-1:0]   good_need;
        logic [CFG_W-1:0]   jump_run;
    } t_cfg;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               below_low;
        logic               above_high;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// File: hdl/bcd_front.sv
`default_nettype none

module bcd_front
    import bcd_pkg::*;
(
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [RATIO_W-1:0] i_received_ratio,
    input  wire t_cfg               i_cfg,
    input  wire t_q_stat            i_q_stat,
    output logic                    o_stall,
    output logic                    o_push,
    output t_item                   o_item
);

    // flags the item against both thresholds before it is queued
    assign o_stall = i_q_stat.full || !i_rst_n;
    assign o_push  = i_valid && !o_stall;

    always_comb begin
        o_item.ratio      = i_received_ratio;
        o_item.below_low  = i_received_ratio < i_cfg.low_thr;
        o_item.above_high = i_received_ratio > i_cfg.high_thr;
    end

endmodule

`default_nettype wire

// File: hdl/bcd_queue.sv
`default_nettype none

module bcd_queue
    import bcd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output t_q_stat    o_stat
);

    t_item      r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count[1];
    assign o_stat.empty = (r_count == 2'd0);

endmodule

`default_nettype wire

// File: hdl/bcd_back.sv
`default_nettype none

module bcd_back
    import bcd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_item            i_item,
    input  wire t_q_stat          i_q_stat,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_stall,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [DEC_W-1:0]      o_decision,
    output logic                  o_at_max_rate
);

    localparam int W    = COUNT_WIDTH;
    localparam int CMPW = (W > CFG_W) ? W : CFG_W;
    localparam logic [W-1:0] CNT_MAX = {W{1'b1}};

    logic [W-1:0]       r_psc, n_psc;
    logic [W-1:0]       r_gpc, n_gpc;
    logic [W-1:0]       r_spc, n_spc;
    logic [W-1:0]       r_cuc, n_cuc;
    logic [CFG_W-1:0]   r_aw, n_aw;
    logic [CFG_W-1:0]   r_jt, n_jt;
    logic               r_lwu, n_lwu;
    logic               r_max, n_max;
    logic [RATIO_W-1:0] r_prev, n_prev;

    logic               r_out_valid;
    logic [DEC_W-1:0]   r_dec, n_dec;
    logic               r_at_max;

    assign o_pop = !i_q_stat.empty && (!r_out_valid || !i_stall);

    always_comb begin
        logic [W-1:0]     psc1, gpc1, spc1, cuc1;
        logic [CFG_W-1:0] aw1, aw2;
        logic             up_ok;

        psc1 = (r_psc == CNT_MAX) ? r_psc : r_psc + 1'b1;
        aw1  = (CMPW'(psc1) >= CMPW'(i_cfg.wait_safe)) ? i_cfg.wait_norm : r_aw;
        gpc1 = (i_item.above_high && r_gpc != CNT_MAX) ? r_gpc + 1'b1 : r_gpc;
        spc1 = r_spc;
        cuc1 = r_cuc;
        aw2  = aw1;
        up_ok = 1'b0;

        n_psc  = psc1;
        n_gpc  = gpc1;
        n_spc  = r_spc;
        n_cuc  = r_cuc;
        n_aw   = aw1;
        n_jt   = r_jt;
        n_lwu  = r_lwu;
        n_max  = r_max;
        n_prev = i_item.ratio;
        n_dec  = DEC_HOLD;

        if (i_item.below_low) begin
            n_psc = '0;
            n_gpc = '0;
            // spiral test runs on the count before it clears
            if (r_lwu && CMPW'(psc1) <= CMPW'(i_cfg.fail_win)) begin
                spc1 = (r_spc == CNT_MAX) ? r_spc : r_spc + 1'b1;
            end else if (!r_lwu && CMPW'(psc1) > CMPW'(i_cfg.fail_win)) begin
                spc1 = '0;
                aw2  = i_cfg.wait_norm;
            end
            n_spc = spc1;
            n_aw  = (CMPW'(spc1) >= CMPW'(i_cfg.spiral_lim)) ? i_cfg.wait_safe : aw2;
            n_lwu = 1'b0;
            n_max = 1'b0;
            n_dec = DEC_DOWN;
        end else begin
            up_ok = (CMPW'(psc1) >= CMPW'(aw1)) &&
                    (CMPW'(gpc1) >= CMPW'(i_cfg.good_need)) &&
                    (r_prev > i_cfg.high_thr);
            if (up_ok) begin
                n_psc = '0;
                n_gpc = '0;
                if (r_lwu) begin
                    n_spc = '0;
                    cuc1  = (r_cuc == CNT_MAX) ? r_cuc : r_cuc + 1'b1;
                end else begin
                    cuc1  = '0;
                end
                n_lwu = 1'b1;
                if (CMPW'(r_jt) <= CMPW'(cuc1) && !r_max) begin
                    n_jt  = i_cfg.jump_run;
                    n_cuc = '0;
                    n_max = 1'b1;
                    n_dec = DEC_JUMP;
                end else begin
                    n_cuc = cuc1;
                    n_dec = r_max ? DEC_HOLD : DEC_UP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psc       <= '0;
            r_gpc       <= '0;
            r_spc       <= '0;
            r_cuc       <= '0;
            r_aw        <= RST_WAIT_NORM;
            r_jt        <= RST_JUMP_NOW;
            r_lwu       <= 1'b0;
            r_max       <= 1'b0;
            r_prev      <= RST_PREV_RATIO;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_psc  <= n_psc;
                r_gpc  <= n_gpc;
                r_spc  <= n_spc;
                r_cuc  <= n_cuc;
                r_aw   <= n_aw;
                r_jt   <= n_jt;
                r_lwu  <= n_lwu;
                r_max  <= n_max;
                r_prev <= n_prev;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dec    <= n_dec;
            r_at_max <= n_max;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_decision    = r_dec;
    assign o_at_max_rate = r_at_max;

endmodule

`default_nettype wire

// File: hdl/bitrate_change_decision.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_stall       i_received_ratio
// result    out        o_valid / i_stall       o_decision, o_at_max_rate
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result side does not stall; an accepted
// item is written into the queue, then popped into the decision register, which
// drives o_decision while o_valid is high.
// The 2-entry queue between classifier and decision logic absorbs a stall
// of the result side while the next item is still taken.
// Reset is synchronous, active low; registers return to their reset values
// and o_stall is held high while reset is asserted.

module bitrate_change_decision
    import bcd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [RATIO_W-1:0]    i_received_ratio,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [DEC_W-1:0]           o_decision,
    output logic                       o_at_max_rate,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_q_stat q_stat;
    t_item   push_item;
    t_item   pop_item;
    logic    push;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_thr    <= RST_LOW_THR;
            r_cfg.high_thr   <= RST_HIGH_THR;
            r_cfg.wait_norm  <= RST_WAIT_NORM;
            r_cfg.wait_safe  <= RST_WAIT_SAFE;
            r_cfg.fail_win   <= RST_FAIL_WIN;
            r_cfg.spiral_lim <= RST_SPIRAL_LIM;
            r_cfg.good_need  <= RST_GOOD_NEED;
            r_cfg.jump_run   <= RST_JUMP_RUN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LOW_THR:    r_cfg.low_thr    <= i_cfg_data;
                REG_HIGH_THR:   r_cfg.high_thr   <= i_cfg_data;
                REG_WAIT_NORM:  r_cfg.wait_norm  <= i_cfg_data[CFG_W-1:0];
                REG_WAIT_SAFE:  r_cfg.wait_safe  <= i_cfg_data[CFG_W-1:0];
                REG_FAIL_WIN:   r_cfg.fail_win   <= i_cfg_data[CFG_W-1:0];
                REG_SPIRAL_LIM: r_cfg.spiral_lim <= i_cfg_data[CFG_W-1:0];
                REG_GOOD_NEED:  r_cfg.good_need  <= i_cfg_data[CFG_W-1:0];
                REG_JUMP_RUN:   r_cfg.jump_run   <= i_cfg_data[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    bcd_front u_front (
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_received_ratio (i_received_ratio),
        .i_cfg            (r_cfg),
        .i_q_stat         (q_stat),
        .o_stall          (o_stall),
        .o_push           (push),
        .o_item           (push_item)
    );

    bcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (q_stat)
    );

    bcd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (pop_item),
        .i_q_stat      (q_stat),
        .i_cfg         (r_cfg),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_decision    (o_decision),
        .o_at_max_rate (o_at_max_rate)
    );

    a_jump_sets_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_decision == DEC_JUMP) |-> o_at_max_rate)
        else $error("jump without at-max flag");

    a_down_clears_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_decision == DEC_DOWN) |-> !o_at_max_rate)
        else $error("step down with at-max flag set");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !push)
        else $error("queue written while full");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bcd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [DEC_W-1:0] decision;
        logic             at_max_rate;
    } decision_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               typed;
        decision_t          result;
    } ratio_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [RATIO_W-1:0]    i_received_ratio = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [DEC_W-1:0]      o_decision;
    logic                  o_at_max_rate;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bitrate_change_decision uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_received_ratio (i_received_ratio),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_decision       (o_decision),
        .o_at_max_rate    (o_at_max_rate),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // rate controller mirror: register copy and decision state
    t_cfg               rate_cfg;
    logic [7:0]         periods_since;
    logic [7:0]         good_periods;
    logic [7:0]         spirals;
    logic [7:0]         up_wait_now;
    logic [7:0]         up_run;
    logic [7:0]         jump_at;
    logic               last_up;
    logic               at_max;
    logic [RATIO_W-1:0] prev_ratio;

    decision_t pending_decisions[$];
    decision_t oldest;
    int        mismatches = 0;
    int        stall_mode = 0;
    int        stall_left = 0;

    // rows marked typed carry a result that is obvious by inspection
    ratio_row_t directed_rows [25] = '{
        '{16'd0,     1'b1, '{DEC_DOWN, 1'b0}},
        '{16'd65535, 1'b1, '{DEC_HOLD, 1'b0}},
        '{16'd23039, 1'b1, '{DEC_DOWN, 1'b0}},
        '{16'd23040, 1'b1, '{DEC_HOLD, 1'b0}},
        '{16'd24832, 1'b1, '{DEC_HOLD, 1'b0}},
        '{16'd24833, 1'b1, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd0,     1'b1, '{DEC_DOWN, 1'b0}},
        '{16'd43690, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd21845, 1'b1, '{DEC_DOWN, 1'b0}},
        '{16'd65535, 1'b0, '{DEC_HOLD, 1'b0}},
        '{16'd32768, 1'b0, '{DEC_HOLD, 1'b0}}
    };

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    task automatic reset_rate_state;
        rate_cfg = '{low_thr: RST_LOW_THR, high_thr: RST_HIGH_THR,
                     wait_norm: RST_WAIT_NORM, wait_safe: RST_WAIT_SAFE,
                     fail_win: RST_FAIL_WIN, spiral_lim: RST_SPIRAL_LIM,
                     good_need: RST_GOOD_NEED, jump_run: RST_JUMP_RUN};
        periods_since = '0;
        good_periods  = '0;
        spirals       = '0;
        up_wait_now   = RST_WAIT_NORM;
        up_run        = '0;
        jump_at       = RST_JUMP_NOW;
        last_up       = 1'b0;
        at_max        = 1'b0;
        prev_ratio    = RST_PREV_RATIO;
    endtask

    // one measurement period of the rate controller; updates the mirror state
    function automatic logic [DEC_W-1:0] next_decision(input logic [RATIO_W-1:0] r);
        logic [7:0] elapsed;
        periods_since = bump(periods_since);
        if (periods_since >= rate_cfg.wait_safe)
            up_wait_now = rate_cfg.wait_norm;
        if (r < rate_cfg.low_thr) begin
            // spiral check looks at the count before it is cleared
            elapsed       = periods_since;
            good_periods  = '0;
            periods_since = '0;
            prev_ratio    = r;
            if (last_up && elapsed <= rate_cfg.fail_win) begin
                spirals = bump(spirals);
            end else if (!last_up && elapsed > rate_cfg.fail_win) begin
                spirals     = '0;
                up_wait_now = rate_cfg.wait_norm;
            end
            if (spirals >= rate_cfg.spiral_lim)
                up_wait_now = rate_cfg.wait_safe;
            last_up = 1'b0;
            at_max  = 1'b0;
            return DEC_DOWN;
        end
        if (r > rate_cfg.high_thr)
            good_periods = bump(good_periods);
        if (periods_since >= up_wait_now && good_periods >= rate_cfg.good_need &&
                prev_ratio > rate_cfg.high_thr) begin
            good_periods  = '0;
            periods_since = '0;
            prev_ratio    = r;
            if (last_up) begin
                spirals = '0;
                up_run  = bump(up_run);
            end else begin
                up_run = '0;
            end
            last_up = 1'b1;
            if (jump_at <= up_run && !at_max) begin
                jump_at = rate_cfg.jump_run;
                up_run  = '0;
                at_max  = 1'b1;
                return DEC_JUMP;
            end
            // up conditions met while already at max: bookkeeping only
            return at_max ? DEC_HOLD : DEC_UP;
        end
        prev_ratio = r;
        return DEC_HOLD;
    endfunction

    task automatic send_ratio(input logic [RATIO_W-1:0] r, input logic typed,
                              input decision_t typed_result);
        decision_t want;
        i_valid          <= 1'b1;
        i_received_ratio <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want.decision    = next_decision(r);
        want.at_max_rate = at_max;
        pending_decisions.push_back(typed ? typed_result : want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_LOW_THR:    rate_cfg.low_thr    = data;
            REG_HIGH_THR:   rate_cfg.high_thr   = data;
            REG_WAIT_NORM:  rate_cfg.wait_norm  = data[7:0];
            REG_WAIT_SAFE:  rate_cfg.wait_safe  = data[7:0];
            REG_FAIL_WIN:   rate_cfg.fail_win   = data[7:0];
            REG_SPIRAL_LIM: rate_cfg.spiral_lim = data[7:0];
            REG_GOOD_NEED:  rate_cfg.good_need  = data[7:0];
            REG_JUMP_RUN:   rate_cfg.jump_run   = data[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
    endtask

    // 8-bit registers get random upper data bits, which must be dropped
    function automatic logic [CFG_DATA_W-1:0] byte_data(input int v);
        return {8'($urandom_range(0, 255)), 8'(v)};
    endfunction

    task automatic program_phase(input int phase);
        int lo, hi, wn, ws, fw, sl, gn, jr;
        case (phase)
            1: begin
                lo = $urandom_range(8000, 20000);
                hi = lo + $urandom_range(0, 3000);
                wn = $urandom_range(1, 4);
                ws = $urandom_range(2, 12);
                fw = $urandom_range(0, 6);
                sl = $urandom_range(1, 3);
                gn = $urandom_range(0, 3);
                jr = $urandom_range(0, 3);
            end
            2: begin
                lo = 0; hi = 0; wn = 0; ws = 0; fw = 0; sl = 0; gn = 0; jr = 0;
            end
            3: begin
                lo = 65535; hi = 65535;
                wn = 255; ws = 255; fw = 255; sl = 255; gn = 255; jr = 255;
            end
            4: begin
                lo = RST_LOW_THR;    hi = RST_HIGH_THR;
                wn = RST_WAIT_NORM;  ws = RST_WAIT_SAFE;
                fw = RST_FAIL_WIN;   sl = RST_SPIRAL_LIM;
                gn = RST_GOOD_NEED;  jr = RST_JUMP_RUN;
            end
            5: begin
                lo = $urandom_range(0, 30000);
                hi = $urandom_range(lo, 40000);
                wn = $urandom_range(0, 20);
                ws = $urandom_range(0, 30);
                fw = $urandom_range(0, 20);
                sl = $urandom_range(0, 6);
                gn = $urandom_range(0, 10);
                jr = $urandom_range(0, 6);
            end
            default: begin
                lo = $urandom_range(0, 65535);
                hi = $urandom_range(0, 65535);
                wn = $urandom_range(0, 255);
                ws = $urandom_range(0, 255);
                fw = $urandom_range(0, 255);
                sl = $urandom_range(0, 255);
                gn = $urandom_range(0, 255);
                jr = $urandom_range(0, 255);
            end
        endcase
        write_reg(REG_LOW_THR, 16'(lo));
        write_reg(REG_HIGH_THR, 16'(hi));
        write_reg(REG_WAIT_NORM, byte_data(wn));
        write_reg(REG_WAIT_SAFE, byte_data(ws));
        write_reg(REG_FAIL_WIN, byte_data(fw));
        write_reg(REG_SPIRAL_LIM, byte_data(sl));
        write_reg(REG_GOOD_NEED, byte_data(gn));
        write_reg(REG_JUMP_RUN, byte_data(jr));
        // unmapped index, must leave every register alone
        if (phase == 1)
            write_reg(8'hFF, 16'($urandom_range(0, 65535)));
        i_cfg_valid <= 1'b0;
    endtask

    // mostly good periods so ups and jumps happen, with downs and noise mixed in
    function automatic logic [RATIO_W-1:0] pick_ratio(input int good_pct);
        int k, lo, hi;
        lo = rate_cfg.low_thr;
        hi = rate_cfg.high_thr;
        k  = $urandom_range(0, 99);
        if (k < good_pct && hi < 65535)
            return 16'($urandom_range(hi + 1, 65535));
        k = $urandom_range(0, 99);
        if (k < 45 && lo > 0)
            return 16'($urandom_range(0, lo - 1));
        if (k < 75 && lo <= hi)
            return 16'($urandom_range(lo, hi));
        if (k < 85)
            return k[0] ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic run_random(input int count);
        int sent, burst, gap, good_pct, sel, n;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            sel   = $urandom_range(0, 2);
            good_pct = (sel == 0) ? 95 : (sel == 1) ? 80 : 50;
            for (n = 0; n < burst && sent < count; n++) begin
                send_ratio(pick_ratio(good_pct), 1'b0, '0);
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // receiver: stretches of no stall, light stall and heavy stall
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 150);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_decisions.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: unexpected result decision=%0d at_max=%0b",
                             o_decision, o_at_max_rate);
                mismatches++;
            end else begin
                oldest = pending_decisions.pop_front();
                if (o_decision !== oldest.decision || o_at_max_rate !== oldest.at_max_rate) begin
                    if (mismatches < 10)
                        $display("ERROR: decision exp %0d got %0d, at_max exp %0b got %0b",
                                 oldest.decision, o_decision, oldest.at_max_rate,
                                 o_at_max_rate);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int row, phase;
        reset_rate_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < 25; row++)
            send_ratio(directed_rows[row].ratio, directed_rows[row].typed,
                       directed_rows[row].result);
        wait_drained();

        for (phase = 1; phase <= 6; phase++) begin
            program_phase(phase);
            case (phase)
                1: run_random(400);
                2: run_random(250);
                3: run_random(150);
                4: run_random(350);
                5: run_random(400);
                default: run_random(250);
            endcase
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_decisions.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
